[hdl/floppy_controller_word_stream_defines.svh]
// Assertion macros for the floppy controller word stream block.
// Used by the top level only; define NO_ASSERTIONS to drop every check.
`ifndef FLOPPY_CONTROLLER_WORD_STREAM_DEFINES_SVH
`define FLOPPY_CONTROLLER_WORD_STREAM_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Implication checked on every rising clock edge outside reset.
`define FCWS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition that must never be seen outside reset.
`define FCWS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define FCWS_ASSERT(lbl, prop, msg)
`define FCWS_NEVER(lbl, cond, msg)
`endif

`endif

[hdl/fcws_pkg.sv]
// Shared constants, defaults and the marker word function of the floppy word stream.
// No dependencies; imported by floppy_controller_word_stream.
`timescale 1ns / 1ps
`default_nettype none

package fcws_pkg;

  // Default geometry
  localparam int SectorsPerTrackDef = 10;
  localparam int SectorWordsDef     = 256;
  localparam int DrivesDef          = 4;

  // Field and bus widths
  localparam int CmdW       = 2;
  localparam int OffW       = 2;
  localparam int WordW      = 16;
  localparam int TrackW     = 7;
  localparam int ImgDriveW  = 2;
  localparam int ImgAddrW   = 19;
  localparam int InDataW    = 40;
  localparam int OutDataW   = 40;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 7;
  localparam int PhaseW     = 3;
  localparam int SectorW    = 4;

  // Bus access kinds and register offsets
  localparam logic [CmdW-1:0] CmdWordRead  = 2'd0;
  localparam logic [CmdW-1:0] CmdWordWrite = 2'd1;
  localparam logic [OffW-1:0] OffCtrl      = 2'd0;
  localparam logic [OffW-1:0] OffData      = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPresent  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgReadonly = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTrack    = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSide     = 2'd3;

  // Stream words
  localparam logic [WordW-1:0] WordFill = 16'o047116;
  localparam logic [WordW-1:0] WordLast = 16'o120641;
  localparam logic [WordW-1:0] WordIdx  = 16'o120776;
  localparam logic [WordW-1:0] WordData = 16'o120773;
  localparam logic [WordW-1:0] WordEnd  = 16'o120770;

  // Marker lengths and filler counts
  localparam logic [4:0] LenIdx    = 5'd24;
  localparam logic [4:0] FillIdx   = 5'd16;
  localparam logic [4:0] LenDmark  = 5'd19;
  localparam logic [4:0] FillDmark = 5'd11;
  localparam logic [4:0] LenEmark  = 5'd26;
  localparam logic [4:0] FillEmark = 5'd18;

  // Control word bit that starts I/O
  localparam int CtrlStartBit = 8;

  // Word at position pos of a marker: filler, zeros, last-before-flag, flag
  function automatic logic [WordW-1:0] marker_word(input logic [4:0] pos,
                                                   input logic [4:0] len,
                                                   input logic [4:0] fill_len,
                                                   input logic [WordW-1:0] flag);
    logic [5:0] pos2;
    logic [WordW-1:0] w;
    pos2 = 6'(pos) + 6'd2;
    if (pos < fill_len) begin
      w = WordFill;
    end else if (pos2 < 6'(len)) begin
      w = '0;
    end else if (pos2 == 6'(len)) begin
      w = WordLast;
    end else begin
      w = flag;
    end
    return w;
  endfunction

endpackage

`default_nettype wire

[hdl/floppy_controller_word_stream.sv]
// Four-drive floppy controller seen as a stream of bus accesses.
// Depends on fcws_pkg and floppy_controller_word_stream_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   The slave stream carries one bus access per beat (cmd, offset, write data,
//   index pulse from the disk timer, and the image word at the address that this
//   access's result reports). The master stream returns one result beat per
//   access: read data, image-read flag, image drive and image word address.
//   The configuration port writes present mask, read-only mask, head track and
//   head side; write it only while no access is in flight.
//   An accepted access is held in the input register, then loads the result
//   register, which offers its result beat. Throughput: one access per cycle
//   while the receiver takes results; the per-drive stream registers are read
//   and updated as an access moves from the input to the result register.
//   Reset clears the configuration, deselects all drives and puts every drive
//   at the index marker, sector 0, I/O inactive; the idle toggle starts so
//   that the first idle data read gives FFFF.
//   When the receiver stalls, the result register holds its beat and the
//   input register takes one more access; after that s_axis_tready drops
//   until the result is taken.

`include "floppy_controller_word_stream_defines.svh"

module floppy_controller_word_stream #(
  parameter int SECTORS_PER_TRACK = fcws_pkg::SectorsPerTrackDef,
  parameter int SECTOR_WORDS      = fcws_pkg::SectorWordsDef,
  parameter int DRIVES            = fcws_pkg::DrivesDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // cmd[1:0], reg_offset[3:2], write_value[19:4], index_pulse[20],
  // image_word[36:21], zero fill [39:37]
  input  wire logic [fcws_pkg::InDataW-1:0]  s_axis_tdata,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // read_data[15:0], image_read[16], image_drive[18:17], image_addr[37:19],
  // zero fill [39:38]
  output logic [fcws_pkg::OutDataW-1:0]      m_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  input  wire logic                          cfg_we_i,
  input  wire logic [fcws_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [fcws_pkg::CfgDataW-1:0] cfg_data_i
);
  import fcws_pkg::*;

  localparam int DrvIdxW = (DRIVES > 1) ? $clog2(DRIVES) : 1;
  localparam int CntW    = $clog2(SECTOR_WORDS);
  localparam int RowW    = $clog2(255 * SECTORS_PER_TRACK + 16);
  localparam int SwW     = $clog2(SECTOR_WORDS + 1);
  localparam int ProdW   = RowW + SwW;
  localparam logic [CntW-1:0]    LastImgCnt = CntW'(SECTOR_WORDS - 1);
  localparam logic [SectorW-1:0] LastSector = SectorW'(SECTORS_PER_TRACK);

  // Stream phases
  localparam logic [PhaseW-1:0] PhIdx     = 3'd0;
  localparam logic [PhaseW-1:0] PhSideTrk = 3'd1;
  localparam logic [PhaseW-1:0] PhSecSize = 3'd2;
  localparam logic [PhaseW-1:0] PhDmark   = 3'd3;
  localparam logic [PhaseW-1:0] PhImage   = 3'd4;
  localparam logic [PhaseW-1:0] PhEmark   = 3'd5;

  // Configuration
  logic [3:0]        present_q;
  logic [3:0]        readonly_q;
  logic [TrackW-1:0] track_q;
  logic              side_q;
  logic [RowW-1:0]   track_row;

  // Drive state
  logic               sel_vld_q;
  logic [DrvIdxW-1:0] sel_q;
  logic [PhaseW-1:0]  phase_q  [DRIVES];
  logic [CntW-1:0]    cnt_q    [DRIVES];
  logic [SectorW-1:0] sector_q [DRIVES];
  logic [DRIVES-1:0]  active_q;
  logic               toggle_q;

  // Input register
  logic                s1_vld_q;
  logic [InDataW-1:0]  s1_data_q;

  // Result register
  logic                m_vld_q;
  logic [WordW-1:0]    res_data_q;
  logic                res_img_q;
  logic [ImgDriveW-1:0] res_drive_q;
  logic [ImgAddrW-1:0] res_addr_q;

  logic fire;
  assign fire          = s1_vld_q && (!m_vld_q || m_axis_tready);
  assign s_axis_tready = !s1_vld_q || fire;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q  <= '0;
      readonly_q <= '0;
      track_q    <= '0;
      side_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgPresent:  present_q  <= cfg_data_i[3:0];
        CfgReadonly: readonly_q <= cfg_data_i[3:0];
        CfgTrack:    track_q    <= cfg_data_i[TrackW-1:0];
        CfgSide:     side_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Track row times sectors per track: first sector of the current track
  assign track_row = RowW'({track_q, side_q} * SECTORS_PER_TRACK);

  // Take in an access beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_data_q <= s_axis_tdata;
    end
  end

  // Unpack the held access
  logic [CmdW-1:0]  in_cmd;
  logic [OffW-1:0]  in_off;
  logic [WordW-1:0] in_wv;
  logic             in_idx;
  logic [WordW-1:0] in_img;
  assign in_cmd = s1_data_q[1:0];
  assign in_off = s1_data_q[3:2];
  assign in_wv  = s1_data_q[19:4];
  assign in_idx = s1_data_q[20];
  assign in_img = s1_data_q[36:21];

  // Current state of the selected drive
  logic [1:0]         sel2;
  logic [PhaseW-1:0]  cur_phase;
  logic [CntW-1:0]    cur_cnt;
  logic [SectorW-1:0] cur_sec;
  logic               cur_act;
  logic               cur_pres;
  assign sel2      = 2'(sel_q);
  assign cur_phase = phase_q[sel_q];
  assign cur_cnt   = cnt_q[sel_q];
  assign cur_sec   = sector_q[sel_q];
  assign cur_act   = active_q[sel_q];
  assign cur_pres  = present_q[sel2];

  // Image address of the current image word
  logic [RowW-1:0]     row_sec;
  logic [ProdW-1:0]    addr_prod;
  logic [ImgAddrW-1:0] img_addr;
  assign row_sec   = RowW'(track_row + RowW'(cur_sec));
  assign addr_prod = ProdW'(row_sec) * ProdW'(SECTOR_WORDS);
  assign img_addr  = ImgAddrW'(addr_prod + ProdW'(cur_cnt));

  // Decode the control write's drive select
  logic [1:0] new_sel;
  logic       new_sel_ok;
  always_comb begin
    if (in_wv[0]) begin
      new_sel = 2'd0;
    end else if (in_wv[1]) begin
      new_sel = 2'd1;
    end else if (in_wv[2]) begin
      new_sel = 2'd2;
    end else begin
      new_sel = 2'd3;
    end
    new_sel_ok = (in_wv[3:0] != 4'd0) && (3'(new_sel) < 3'(DRIVES));
  end

  // Work out the result and the next drive state
  logic                ret;
  logic [WordW-1:0]    res_data_d;
  logic                res_img_d;
  logic [ImgAddrW-1:0] res_addr_d;
  logic                drv_we;
  logic [PhaseW-1:0]   phase_d;
  logic [CntW-1:0]     cnt_d;
  logic [SectorW-1:0]  sec_d;
  logic                act_d;
  logic                toggle_d;
  logic                sel_we;
  logic [CntW-1:0]     idx_cnt;
  logic [CntW-1:0]     cnt_inc;

  always_comb begin
    ret        = 1'b0;
    res_data_d = '0;
    res_img_d  = 1'b0;
    res_addr_d = '0;
    drv_we     = 1'b0;
    phase_d    = cur_phase;
    cnt_d      = cur_cnt;
    sec_d      = cur_sec;
    act_d      = cur_act;
    toggle_d   = toggle_q;
    sel_we     = 1'b0;
    idx_cnt    = (cur_cnt >= CntW'(LenIdx)) ? '0 : cur_cnt;
    cnt_inc    = cur_cnt + CntW'(1);

    if (in_cmd == CmdWordRead && in_off == OffCtrl) begin
      // Status read; index pulse restarts the selected drive
      if (sel_vld_q) begin
        drv_we = 1'b1;
        if (in_idx) begin
          if (cur_phase != PhSideTrk && cur_phase != PhSecSize) begin
            phase_d = PhIdx;
            cnt_d   = '0;
          end
          sec_d = '0;
          act_d = cur_pres;
        end
        res_data_d = {in_idx, 1'b0, 6'b0, act_d, 4'b0, readonly_q[sel2], cur_pres,
                      (track_q == '0)};
      end
    end else if (in_cmd == CmdWordRead && in_off == OffData) begin
      if (sel_vld_q && cur_act) begin
        drv_we = 1'b1;
        case (cur_phase)
          PhSideTrk: begin
            res_data_d = {7'b0, side_q, 1'b0, track_q};
            phase_d    = PhSecSize;
          end
          PhSecSize: begin
            res_data_d = {3'b0, 5'(cur_sec) + 5'd1, 8'h02};
            phase_d    = PhDmark;
            cnt_d      = '0;
          end
          PhDmark: begin
            res_data_d = marker_word(cur_cnt[4:0], LenDmark, FillDmark, WordData);
            if (cnt_inc >= CntW'(LenDmark)) begin
              phase_d = PhImage;
              cnt_d   = '0;
            end else begin
              cnt_d = cnt_inc;
            end
          end
          PhImage: begin
            if (cur_pres) begin
              res_data_d = in_img;
              res_img_d  = 1'b1;
              res_addr_d = img_addr;
            end
            if (cur_cnt == LastImgCnt) begin
              phase_d = PhEmark;
              cnt_d   = '0;
            end else begin
              cnt_d = cnt_inc;
            end
          end
          PhEmark: begin
            res_data_d = marker_word(cur_cnt[4:0], LenEmark, FillEmark, WordEnd);
            if (cnt_inc >= CntW'(LenEmark)) begin
              sec_d   = cur_sec + SectorW'(1);
              phase_d = PhIdx;
              cnt_d   = '0;
              if (sec_d == LastSector) begin
                act_d = 1'b0;
              end
            end else begin
              cnt_d = cnt_inc;
            end
          end
          default: begin
            // Index marker, also for codes outside the phase list
            res_data_d = marker_word(idx_cnt[4:0], LenIdx, FillIdx, WordIdx);
            if (idx_cnt + CntW'(1) >= CntW'(LenIdx)) begin
              phase_d = PhSideTrk;
              cnt_d   = '0;
            end else begin
              phase_d = PhIdx;
              cnt_d   = idx_cnt + CntW'(1);
            end
          end
        endcase
      end else begin
        // Idle data read alternates FFFF and 0000
        toggle_d   = ~toggle_q;
        res_data_d = {WordW{toggle_d}};
      end
    end else if (in_cmd == CmdWordWrite && in_off == OffCtrl) begin
      sel_we = 1'b1;
    end
    ret = res_img_d;
  end

  // Update drive state on each processed access
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_vld_q <= 1'b0;
      sel_q     <= '0;
      active_q  <= '0;
      toggle_q  <= 1'b0;
      for (int i = 0; i < DRIVES; i++) begin
        phase_q[i]  <= PhIdx;
        cnt_q[i]    <= '0;
        sector_q[i] <= '0;
      end
    end else if (fire) begin
      toggle_q <= toggle_d;
      if (sel_we) begin
        sel_vld_q <= new_sel_ok;
        sel_q     <= DrvIdxW'(new_sel);
        if (new_sel_ok && in_wv[CtrlStartBit]) begin
          active_q[DrvIdxW'(new_sel)] <= 1'b1;
        end
      end else if (drv_we) begin
        phase_q[sel_q]  <= phase_d;
        cnt_q[sel_q]    <= cnt_d;
        sector_q[sel_q] <= sec_d;
        active_q[sel_q] <= act_d;
      end
    end
  end

  // Result register: load on fire, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (fire) begin
      m_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_data_q  <= res_data_d;
      res_img_q   <= ret;
      res_drive_q <= ret ? sel2 : 2'd0;
      res_addr_q  <= res_addr_d;
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = {2'b0, res_addr_q, res_drive_q, res_img_q, res_data_q};

  // Checks
  `FCWS_ASSERT(a_fire_loads_result, fire |=> m_axis_tvalid, "processed access left no result")
  `FCWS_ASSERT(a_full_blocks_input,
               s1_vld_q && m_vld_q && !m_axis_tready |-> !s_axis_tready,
               "input taken while both stages full")
  `FCWS_NEVER(a_no_image_addr_idle,
              m_vld_q && !res_img_q && (res_addr_q != '0 || res_drive_q != '0),
              "image address reported without image read")

endmodule

`default_nettype wire

[bench/tb.sv]
// Self-checking bench for the floppy controller word stream: drives bus-access beats,
// predicts each reply beat in place and compares it field by field.
// Depends on fcws_pkg and floppy_controller_word_stream.
`timescale 1ns / 1ps

module tb;
  import fcws_pkg::*;

  // Geometry of the instance under test
  localparam int SectorsPerTrack = SectorsPerTrackDef;
  localparam int SectorWords     = SectorWordsDef;
  localparam int Drives          = DrivesDef;

  // Marker lengths as plain integers
  localparam int IndexLen     = LenIdx;
  localparam int IndexFill    = FillIdx;
  localparam int DataMarkLen  = LenDmark;
  localparam int DataMarkFill = FillDmark;
  localparam int EndMarkLen   = LenEmark;
  localparam int EndMarkFill  = FillEmark;
  localparam int WordsPerSector = IndexLen + 2 + DataMarkLen + SectorWords + EndMarkLen;

  // Access kinds and offsets that the package leaves unnamed
  localparam logic [CmdW-1:0] CmdByteWrite     = 2'd2;
  localparam logic [CmdW-1:0] CmdByteWriteHigh = 2'd3;
  localparam logic [OffW-1:0] OffOddLow        = 2'd1;
  localparam logic [OffW-1:0] OffOddHigh       = 2'd3;

  localparam logic [2:0] NoDrive = 3'd7;

  localparam int StallLimit   = 1000;
  localparam int SettleCycles = 8;
  localparam int HoldOffSpan  = 80;

  typedef enum logic [PhaseW-1:0] {
    PhIndex      = 3'd0,
    PhSideTrack  = 3'd1,
    PhSectorSize = 3'd2,
    PhDataMark   = 3'd3,
    PhImage      = 3'd4,
    PhEndMark    = 3'd5
  } stream_phase_e;

  typedef struct packed {
    logic [ImgAddrW-1:0]  addr;
    logic [ImgDriveW-1:0] drv;
    logic                 img;
    logic [WordW-1:0]     rdata;
  } reply_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // Controller state mirrored on the bench side
  logic [3:0]       present_q, readonly_q;
  logic [TrackW-1:0] track_q;
  logic             side_q;
  logic [2:0]       sel_drive;
  stream_phase_e    drv_phase  [Drives];
  logic [8:0]       drv_count  [Drives];
  logic [SectorW-1:0] drv_sector [Drives];
  logic             drv_active [Drives];
  logic             idle_word;

  reply_t replies_due [$];
  int beats_sent;
  int replies_checked;
  int mismatches;
  int idle_cycles;
  int holdoff_left;
  bit send_gaps_on;
  bit recv_gaps_on;

  floppy_controller_word_stream uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Word at a position of a marker: fillers, zeros, the word before the flag, the flag
  function automatic logic [WordW-1:0] marker_at(input int pos, input int len, input int nfill,
                                                 input logic [WordW-1:0] flag);
    if (pos < nfill) return WordFill;
    if (pos + 2 < len) return '0;
    if (pos + 2 == len) return WordLast;
    return flag;
  endfunction

  // Advance the stream of an active drive by one data read
  function automatic reply_t next_stream_word(input int d, input logic [WordW-1:0] iw);
    reply_t r;
    int cnt;
    int addr;
    r = '0;
    cnt = drv_count[d];
    case (drv_phase[d])
      PhSideTrack: begin
        r.rdata = {7'b0, side_q, 1'b0, track_q};
        drv_phase[d] = PhSectorSize;
      end
      PhSectorSize: begin
        r.rdata = {3'b0, 5'(drv_sector[d]) + 5'd1, 8'h02};
        drv_phase[d] = PhDataMark;
        drv_count[d] = '0;
      end
      PhDataMark: begin
        r.rdata = marker_at(cnt, DataMarkLen, DataMarkFill, WordData);
        cnt++;
        if (cnt >= DataMarkLen) begin
          drv_phase[d] = PhImage;
          cnt = 0;
        end
        drv_count[d] = 9'(cnt);
      end
      PhImage: begin
        addr = ((int'(track_q) * 2 + int'(side_q)) * SectorsPerTrack + int'(drv_sector[d]))
               * SectorWords + cnt;
        if (present_q[d]) begin
          r.rdata = iw;
          r.img   = 1'b1;
          r.drv   = 2'(d);
          r.addr  = 19'(addr);
        end
        cnt++;
        if (cnt >= SectorWords) begin
          drv_phase[d] = PhEndMark;
          cnt = 0;
        end
        drv_count[d] = 9'(cnt);
      end
      PhEndMark: begin
        r.rdata = marker_at(cnt, EndMarkLen, EndMarkFill, WordEnd);
        cnt++;
        if (cnt >= EndMarkLen) begin
          drv_sector[d] = drv_sector[d] + 4'd1;
          if (drv_sector[d] == SectorsPerTrack) drv_active[d] = 1'b0;
          drv_phase[d] = PhIndex;
          cnt = 0;
        end
        drv_count[d] = 9'(cnt);
      end
      default: begin
        if (cnt >= IndexLen) cnt = 0;
        r.rdata = marker_at(cnt, IndexLen, IndexFill, WordIdx);
        cnt++;
        if (cnt >= IndexLen) begin
          drv_phase[d] = PhSideTrack;
          cnt = 0;
        end else begin
          drv_phase[d] = PhIndex;
        end
        drv_count[d] = 9'(cnt);
      end
    endcase
    return r;
  endfunction

  // Reply of the controller to one bus access, updating the mirrored state
  function automatic reply_t controller_reply(input logic [1:0] cmd, input logic [1:0] off,
                                              input logic [15:0] wv, input logic idx,
                                              input logic [15:0] iw);
    reply_t r;
    logic [2:0] pick;
    int d;
    r = '0;
    d = int'(sel_drive);
    if (cmd == CmdWordRead && off == OffCtrl) begin
      if (sel_drive != NoDrive) begin
        // index pulse restarts the sector count; pending header words survive it
        if (idx) begin
          if (drv_phase[d] != PhSideTrack && drv_phase[d] != PhSectorSize) begin
            drv_phase[d] = PhIndex;
            drv_count[d] = '0;
          end
          drv_sector[d] = '0;
          drv_active[d] = present_q[d];
        end
        r.rdata = {idx, 1'b0, 6'b0, drv_active[d], 4'b0, readonly_q[d], present_q[d],
                   track_q == '0};
      end
    end else if (cmd == CmdWordRead && off == OffData) begin
      if (sel_drive != NoDrive && drv_active[d]) begin
        r = next_stream_word(d, iw);
      end else begin
        idle_word = ~idle_word;
        r.rdata = {WordW{idle_word}};
      end
    end else if (cmd == CmdWordWrite && off == OffCtrl) begin
      // lowest set bit of the low nibble picks the drive
      if (wv[3:0] == 4'd0) pick = NoDrive;
      else if (wv[0]) pick = 3'd0;
      else if (wv[1]) pick = 3'd1;
      else if (wv[2]) pick = 3'd2;
      else pick = 3'd3;
      if (pick >= Drives) pick = NoDrive;
      sel_drive = pick;
      if (pick != NoDrive && wv[CtrlStartBit]) drv_active[pick] = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Offer one access beat and hold it until it is taken
  task automatic send_access(input logic [1:0] cmd, input logic [1:0] off,
                             input logic [15:0] wv, input logic idx, input logic [15:0] iw);
    reply_t want;
    while (send_gaps_on && $urandom_range(99) < 23) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b0, iw, idx, wv, off, cmd};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    want = controller_reply(cmd, off, wv, idx, iw);
    replies_due.push_back(want);
    beats_sent++;
  endtask

  task automatic read_data_word();
    send_access(CmdWordRead, OffData, 16'($urandom), 1'($urandom_range(1)), 16'($urandom));
  endtask

  task automatic read_status(input logic idx);
    send_access(CmdWordRead, OffCtrl, 16'($urandom), idx, 16'($urandom));
  endtask

  task automatic write_control(input logic [15:0] wv);
    send_access(CmdWordWrite, OffCtrl, wv, 1'($urandom_range(1)), 16'($urandom));
  endtask

  // Stop offering and wait until every reply is back
  task automatic drain_replies();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (replies_due.size() != 0);
  endtask

  // Write all four registers; call only with the block idle
  task automatic load_config(input logic [3:0] present, input logic [3:0] ro,
                             input logic [TrackW-1:0] trk, input logic side);
    logic [CfgDataW-1:0] vals [4];
    vals[CfgPresent]  = 7'(present);
    vals[CfgReadonly] = 7'(ro);
    vals[CfgTrack]    = trk;
    vals[CfgSide]     = 7'(side);
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= 2'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i   <= 1'b0;
    present_q  = present;
    readonly_q = ro;
    track_q    = trk;
    side_q     = side;
  endtask

  // Check each reply beat against the oldest prediction; drive the receiver's ready
  always @(posedge clk_i) begin : reply_check
    reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (replies_due.size() == 0) begin
        report_mismatch($sformatf("reply %h with no access waiting", m_axis_tdata));
      end else begin
        want = replies_due.pop_front();
        if (m_axis_tdata[15:0] !== want.rdata)
          report_mismatch($sformatf("read_data %h, want %h", m_axis_tdata[15:0], want.rdata));
        if (m_axis_tdata[16] !== want.img)
          report_mismatch($sformatf("image_read %b, want %b", m_axis_tdata[16], want.img));
        if (m_axis_tdata[18:17] !== want.drv)
          report_mismatch($sformatf("image_drive %0d, want %0d", m_axis_tdata[18:17],
                                    want.drv));
        if (m_axis_tdata[37:19] !== want.addr)
          report_mismatch($sformatf("image_addr %0d, want %0d", m_axis_tdata[37:19],
                                    want.addr));
        replies_checked++;
      end
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      m_axis_tready <= 1'b0;
    end else if (recv_gaps_on) begin
      m_axis_tready <= ($urandom_range(99) >= 23);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // End the run when no beat moves on either side for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
    else if (rst_ni) idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Reset values, every access kind, odd offsets and the idle toggle
  task automatic test_directed();
    load_config(4'b1011, 4'b0101, 7'd0, 1'b0);
    read_status(1'b1);
    read_data_word();
    read_data_word();
    send_access(CmdByteWrite, OffCtrl, 16'hFFFF, 1'b1, 16'hFFFF);
    send_access(CmdByteWriteHigh, OffData, 16'hFFFF, 1'b1, 16'hFFFF);
    send_access(CmdWordRead, OffOddLow, 16'hFFFF, 1'b1, 16'hFFFF);
    send_access(CmdWordRead, OffOddHigh, 16'h0000, 1'b0, 16'h0000);
    send_access(CmdWordWrite, OffData, 16'hFFFF, 1'b1, 16'hFFFF);
    write_control(16'h0000);
    write_control(16'h000F);
    read_status(1'b0);
    read_data_word();
    write_control(16'hFFF2);
    read_status(1'b0);
    read_data_word();
    read_data_word();
    read_status(1'b1);
    read_data_word();
    // absent drive: an index pulse leaves it inactive
    write_control(16'h0104);
    read_status(1'b1);
    read_data_word();
    write_control(16'h0108);
    read_data_word();
  endtask

  // Walk one sector of a track and on into the headers of the next
  task automatic test_track_walk();
    drain_replies();
    load_config(4'hF, 4'h0, 7'd79, 1'b1);
    write_control(16'h0101);
    repeat (IndexLen) read_data_word();
    // index pulses at the two header words keep them pending
    read_status(1'b1);
    read_data_word();
    read_status(1'b1);
    read_data_word();
    read_status(1'b1);
    repeat (WordsPerSector) read_data_word();
    repeat (30) read_data_word();
  endtask

  // Hold the receiver off while accesses keep coming so the input stalls
  task automatic test_backpressure();
    send_gaps_on = 1'b0;
    holdoff_left = HoldOffSpan;
    write_control(16'h0102);
    repeat (40) read_data_word();
    send_gaps_on = 1'b1;
  endtask

  // Either a drive select with a burst of reads, or one random access
  task automatic random_episode();
    int burst;
    int pick;
    logic [3:0] nib;
    logic [15:0] wv;
    if ($urandom_range(99) < 60) begin
      pick = $urandom_range(9);
      if (pick < 8) nib = 4'(1 << (pick % 4));
      else nib = 4'($urandom_range(15));
      wv = 16'($urandom);
      wv[3:0] = nib;
      wv[CtrlStartBit] = ($urandom_range(9) != 0);
      write_control(wv);
      burst = $urandom_range(1, 120);
      repeat (burst) begin
        if ($urandom_range(99) < 3) read_status(1'($urandom_range(1)));
        else read_data_word();
      end
    end else begin
      send_access(2'($urandom), 2'($urandom), 16'($urandom), 1'($urandom_range(1)),
                  16'($urandom));
    end
  endtask

  // Random traffic in several configuration phases, one without any idling
  task automatic test_random_traffic();
    int target;
    for (int ph = 0; ph < 4; ph++) begin
      drain_replies();
      case (ph)
        0: load_config(4'($urandom), 4'($urandom), 7'($urandom_range(79)), 1'($urandom));
        1: load_config(4'h0, 4'hF, 7'd0, 1'b0);
        2: load_config(4'hF, 4'h0, 7'd79, 1'b1);
        default: load_config(4'($urandom), 4'($urandom), 7'($urandom_range(1, 79)),
                             1'($urandom));
      endcase
      send_gaps_on = (ph != 2);
      recv_gaps_on = (ph != 2);
      target = beats_sent + 200;
      while (beats_sent < target) random_episode();
    end
    send_gaps_on = 1'b1;
    recv_gaps_on = 1'b1;
  endtask

  initial begin
    present_q    = '0;
    readonly_q   = '0;
    track_q      = '0;
    side_q       = 1'b0;
    sel_drive    = NoDrive;
    idle_word    = 1'b0;
    for (int i = 0; i < Drives; i++) begin
      drv_phase[i]  = PhIndex;
      drv_count[i]  = '0;
      drv_sector[i] = '0;
      drv_active[i] = 1'b0;
    end
    beats_sent      = 0;
    replies_checked = 0;
    mismatches      = 0;
    idle_cycles     = 0;
    holdoff_left    = 0;
    send_gaps_on    = 1'b1;
    recv_gaps_on    = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_track_walk();
    test_backpressure();
    test_random_traffic();
    drain_replies();
    repeat (SettleCycles) @(posedge clk_i);
    $display("Ran %0d bus accesses, %0d replies checked, %0d mismatches.", beats_sent,
             replies_checked, mismatches);
    $display("Covered status, control, idle reads, a sector walk with index pulses,");
    $display("a long receiver hold-off and random bursts over several configurations.");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[floppy_controller_word_stream.f]
+incdir+hdl
hdl/fcws_pkg.sv
hdl/floppy_controller_word_stream.sv
bench/tb.sv
